// ===== rtl/vfa_pkg.sv =====
// Package with the types, operation codes and saturation helper of the vector ALU.
`default_nettype none
package vfa_pkg;
	localparam int WORD_W = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SQ_STAGES = 32;

	localparam logic [3:0] OP_SUM = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_SCALE = 4'd3;
	localparam logic [3:0] OP_ADDSCALE = 4'd4;
	localparam logic [3:0] OP_CROSS = 4'd5;
	localparam logic [3:0] OP_DOT = 4'd6;
	localparam logic [3:0] OP_LENGTH = 4'd7;
	localparam logic [3:0] OP_NORM = 4'd8;
	localparam logic [3:0] OP_ABS = 4'd9;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [63:0] wide_t;

	typedef struct packed {
		logic [3:0] mode;
		word_t a_x;
		word_t a_y;
		word_t a_z;
		word_t b_x;
		word_t b_y;
		word_t b_z;
		word_t scale_factor;
	} in_item_t;

	typedef struct packed {
		word_t r_x;
		word_t r_y;
		word_t r_z;
		word_t scalar_out;
		logic overflow;
		logic zero_length;
	} out_item_t;

	typedef struct packed {
		logic [3:0] mode;
		logic [2:0][WORD_W-1:0] a;
		logic [2:0][63:0] val;
		logic [63:0] dot;
	} side_t;

	typedef struct packed {
		logic ovf;
		word_t val;
	} sat_t;

	function automatic sat_t sat32(wide_t v);
		sat_t r;
		r.ovf = 1'b0;
		r.val = v[WORD_W-1:0];
		if (v > 64'sd2147483647) begin
			r.ovf = 1'b1;
			r.val = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r.ovf = 1'b1;
			r.val = 32'sh80000000;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/vfa_if.sv =====
// Valid/ready channel interface that carries one item.
`default_nettype none
interface vfa_if #(parameter type item_t = logic);
	logic valid;
	logic ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/vfa_lane.sv =====
// One component lane: operand selection, two multipliers and the per-component combine.
`default_nettype none
module vfa_lane import vfa_pkg::*; #(
	parameter int LANE = 0,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic [3:0] mode,
	input wire word_t a [3],
	input wire word_t b [3],
	input wire word_t k,
	output wide_t val,
	output logic [63:0] sq
);
	localparam int J = (LANE + 1) % 3;
	localparam int K = (LANE + 2) % 3;

	word_t pa, pb, qa, qb;
	word_t pa_s1, pb_s1, qa_s1, qb_s1, ai_s1, bi_s1, ai_s2, bi_s2;
	logic [3:0] mode_s1, mode_s2;
	wide_t p_s2, q_s2, val_s3;
	logic [63:0] sq_s3;
	wide_t fl_p, fl_q, ai_w, bi_w;

	always_comb begin
		pa = '0;
		pb = '0;
		qa = '0;
		qb = '0;
		case (mode)
			OP_MUL, OP_DOT: begin
				pa = a[LANE];
				pb = b[LANE];
			end
			OP_SCALE: begin
				pa = a[LANE];
				pb = k;
			end
			OP_ADDSCALE: begin
				pa = b[LANE];
				pb = k;
			end
			OP_CROSS: begin
				pa = a[J];
				pb = b[K];
				qa = a[K];
				qb = b[J];
			end
			OP_LENGTH, OP_NORM: begin
				pa = a[LANE];
				pb = a[LANE];
			end
			default: begin
				pa = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s1 <= '0;
			mode_s2 <= '0;
		end else if (en) begin
			mode_s1 <= mode;
			mode_s2 <= mode_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= pa;
			pb_s1 <= pb;
			qa_s1 <= qa;
			qb_s1 <= qb;
			ai_s1 <= a[LANE];
			bi_s1 <= b[LANE];
			p_s2 <= pa_s1 * pb_s1;
			q_s2 <= qa_s1 * qb_s1;
			ai_s2 <= ai_s1;
			bi_s2 <= bi_s1;
			sq_s3 <= p_s2;
		end
	end

	wide_t nxt;
	assign fl_p = p_s2 >>> FRAC_BITS;
	assign fl_q = q_s2 >>> FRAC_BITS;
	assign ai_w = signed'({{32{ai_s2[WORD_W-1]}}, ai_s2});
	assign bi_w = signed'({{32{bi_s2[WORD_W-1]}}, bi_s2});

	always_comb begin
		case (mode_s2)
			OP_SUM: nxt = ai_w + bi_w;
			OP_SUB: nxt = ai_w - bi_w;
			OP_MUL, OP_SCALE, OP_DOT: nxt = fl_p;
			OP_ADDSCALE: nxt = ai_w + fl_p;
			OP_CROSS: nxt = fl_p - fl_q;
			OP_ABS: nxt = (ai_w < 0) ? -ai_w : ai_w;
			default: nxt = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s3 <= nxt;
		end
	end

	assign val = val_s3;
	assign sq = sq_s3;
endmodule
`default_nettype wire

// ===== rtl/vfa_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module vfa_isqrt import vfa_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire logic [63:0] x,
	output logic [SQ_STAGES-1:0] root
);
	logic [63:0] rem_q [SQ_STAGES];
	logic [SQ_STAGES-1:0] root_q [SQ_STAGES];

	for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
		localparam int BIT = SQ_STAGES - 1 - s;
		logic [63:0] rem_in, trial;
		logic [SQ_STAGES-1:0] root_in;
		if (s == 0) begin : g_first
			assign rem_in = x;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[s-1];
			assign root_in = root_q[s-1];
		end
		assign trial = ({32'b0, root_in} << (BIT + 1)) + (64'd1 << (2 * BIT));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_q[s] <= rem_in - trial;
					root_q[s] <= root_in | (SQ_STAGES'(1) << BIT);
				end else begin
					rem_q[s] <= rem_in;
					root_q[s] <= root_in;
				end
			end
		end
	end

	assign root = root_q[SQ_STAGES-1];
endmodule
`default_nettype wire

// ===== rtl/vfa_div.sv =====
// Pipelined restoring divider of a magnitude shifted by the fraction bits, one quotient bit a stage.
`default_nettype none
module vfa_div import vfa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [WORD_W-1:0] n,
	input wire logic [WORD_W-1:0] d,
	output logic [FRAC_BITS:0] q
);
	localparam int NW = WORD_W + FRAC_BITS + 1;
	localparam int ST = FRAC_BITS + 1;

	logic [NW-1:0] rem_q [ST];
	logic [WORD_W-1:0] d_q [ST];
	logic [FRAC_BITS:0] q_q [ST];

	for (genvar s = 0; s < ST; s++) begin : g_stage
		localparam int BIT = FRAC_BITS - s;
		logic [NW-1:0] rem_in, sub;
		logic [WORD_W-1:0] d_in;
		logic [FRAC_BITS:0] q_in;
		if (s == 0) begin : g_first
			assign rem_in = {1'b0, n, {FRAC_BITS{1'b0}}};
			assign d_in = d;
			assign q_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[s-1];
			assign d_in = d_q[s-1];
			assign q_in = q_q[s-1];
		end
		assign sub = NW'(d_in) << BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				d_q[s] <= d_in;
				if (rem_in >= sub) begin
					rem_q[s] <= rem_in - sub;
					q_q[s] <= q_in | ((FRAC_BITS + 1)'(1) << BIT);
				end else begin
					rem_q[s] <= rem_in;
					q_q[s] <= q_in;
				end
			end
		end
	end

	assign q = q_q[ST-1];
endmodule
`default_nettype wire

// ===== rtl/vec3_fixed_point_alu.sv =====
// Top level of the three-component fixed-point vector ALU.
//
// Channel  Direction  Payload
// in       sink       mode, a_x..a_z, b_x..b_z, scale_factor
// out      source     r_x, r_y, r_z, scalar_out, overflow, zero_length
//
// One item is accepted per cycle, except while a result waits in the output register and out is not ready.
// Each item passes through the 32-stage square root followed by the FRAC_BITS + 1 stage divider.
// Reset clears all valid flags; no clearing pass is needed.
// The whole pipeline holds while a result waits in the output register.
`default_nettype none
module vec3_fixed_point_alu import vfa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	vfa_if.sink in,
	vfa_if.source out
);
	localparam int DIV_STAGES = FRAC_BITS + 1;
	localparam int L = SQ_STAGES + DIV_STAGES;

	logic en;
	word_t a [3];
	word_t b [3];
	wide_t val [3];
	logic [63:0] sq [3];
	logic v_s1, v_s2, v_s3, v_s4;
	logic [L-1:0] vpipe_q;
	logic out_valid_q;
	out_item_t out_q;
	side_t side_s1, side_s2, side_s3, side_s4;
	side_t pipe_q [L];
	logic [63:0] sqsum_s4;
	logic [SQ_STAGES-1:0] root;
	logic [SQ_STAGES-1:0] rt_q [DIV_STAGES];
	logic [FRAC_BITS:0] quo [3];

	assign en = !out_valid_q || out.ready;
	assign in.ready = en;
	assign a[0] = in.data.a_x;
	assign a[1] = in.data.a_y;
	assign a[2] = in.data.a_z;
	assign b[0] = in.data.b_x;
	assign b[1] = in.data.b_y;
	assign b[2] = in.data.b_z;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		vfa_lane #(.LANE(i), .FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.mode(in.data.mode),
			.a(a),
			.b(b),
			.k(in.data.scale_factor),
			.val(val[i]),
			.sq(sq[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			vpipe_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vpipe_q <= {vpipe_q[L-2:0], v_s4};
			out_valid_q <= vpipe_q[L-1];
		end
	end

	side_t side_in;
	always_comb begin
		side_in = '0;
		side_in.mode = in.data.mode;
		side_in.a = {in.data.a_z, in.data.a_y, in.data.a_x};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4.mode <= side_s3.mode;
			side_s4.a <= side_s3.a;
			side_s4.val <= {val[2], val[1], val[0]};
			side_s4.dot <= val[0] + val[1] + val[2];
			sqsum_s4 <= sq[0] + sq[1] + sq[2];
			pipe_q[0] <= side_s4;
			for (int i = 1; i < L; i++) begin
				pipe_q[i] <= pipe_q[i-1];
			end
			rt_q[0] <= root;
			for (int i = 1; i < DIV_STAGES; i++) begin
				rt_q[i] <= rt_q[i-1];
			end
		end
	end

	vfa_isqrt u_isqrt (
		.clk(clk),
		.en(en),
		.x(sqsum_s4),
		.root(root)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		logic [WORD_W-1:0] ai, mag;
		assign ai = pipe_q[SQ_STAGES-1].a[i];
		assign mag = ai[WORD_W-1] ? (~ai + 1'b1) : ai;
		vfa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk(clk),
			.en(en),
			.n(mag),
			.d(root),
			.q(quo[i])
		);
	end

	side_t fin;
	logic [SQ_STAGES-1:0] fin_root;
	out_item_t res;
	wide_t vec [3];
	wide_t scal;
	logic has_vec, has_scal, zl;
	sat_t sv [3];
	sat_t ss;

	assign fin = pipe_q[L-1];
	assign fin_root = rt_q[DIV_STAGES-1];

	always_comb begin
		has_vec = 1'b0;
		has_scal = 1'b0;
		zl = 1'b0;
		scal = '0;
		for (int i = 0; i < 3; i++) begin
			vec[i] = signed'(fin.val[i]);
		end
		case (fin.mode)
			OP_SUM, OP_SUB, OP_MUL, OP_SCALE, OP_ADDSCALE, OP_CROSS, OP_ABS: begin
				has_vec = 1'b1;
			end
			OP_DOT: begin
				has_scal = 1'b1;
				scal = signed'(fin.dot);
			end
			OP_LENGTH: begin
				has_scal = 1'b1;
				scal = signed'({32'b0, fin_root});
			end
			OP_NORM: begin
				has_vec = 1'b1;
				zl = (fin_root == '0);
				for (int i = 0; i < 3; i++) begin
					if (zl) begin
						vec[i] = signed'({{32{fin.a[i][WORD_W-1]}}, fin.a[i]});
					end else if (fin.a[i][WORD_W-1]) begin
						vec[i] = -signed'(64'(quo[i]));
					end else begin
						vec[i] = signed'(64'(quo[i]));
					end
				end
			end
			default: begin
				has_vec = 1'b0;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			sv[i] = has_vec ? sat32(vec[i]) : '0;
		end
		ss = has_scal ? sat32(scal) : '0;
		res.r_x = sv[0].val;
		res.r_y = sv[1].val;
		res.r_z = sv[2].val;
		res.scalar_out = ss.val;
		res.overflow = sv[0].ovf | sv[1].ovf | sv[2].ovf | ss.ovf;
		res.zero_length = zl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

	assign out.valid = out_valid_q;
	assign out.data = out_q;

	a_zl_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.data.zero_length |-> !out.data.overflow)
		else $error("zero_length raised together with overflow");
	a_zl_no_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.data.zero_length |-> out.data.scalar_out == '0)
		else $error("zero_length raised with a scalar result");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in.ready |-> out.valid && !out.ready)
		else $error("input stalled without a waiting result");
endmodule
`default_nettype wire
